// ===== rtl/cvss_pkg.sv =====
// ============================================================================
// cvss_pkg: shared constants, types and helpers for the complex value stack
// Holds the store depth, field widths, command and status codes, and the
// circular slot arithmetic used by the core.
// ============================================================================
`default_nettype none

package cvss_pkg;

    // Store geometry
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int DATA_W = 64;
    localparam int POS_W  = 4;
    localparam int OCC_W  = 5;
    localparam int ST_W   = 2;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ST_W-1:0]   t_status;
    typedef logic [DATA_W-1:0] t_data;

    // Command codes
    localparam t_cmd CMD_PUSH_TOP    = 2'd0;
    localparam t_cmd CMD_POP_TOP     = 2'd1;
    localparam t_cmd CMD_PUSH_BOTTOM = 2'd2;
    localparam t_cmd CMD_SEARCH      = 2'd3;

    // Status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Next slot up, wrapping at the end of the store.
    function automatic t_addr f_slot_next(input t_addr a);
        t_addr res;
        if (a == t_addr'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = a + t_addr'(1);
        end
        return res;
    endfunction

    // Slot b entries below slot a, modulo the store depth (b <= DEPTH).
    function automatic t_addr f_slot_back(input t_addr a, input t_cnt b);
        logic [CNT_W:0] a_ext;
        logic [CNT_W:0] b_ext;
        logic [CNT_W:0] diff;
        a_ext = (CNT_W + 1)'(a);
        b_ext = (CNT_W + 1)'(b);
        if (a_ext >= b_ext) begin
            diff = a_ext - b_ext;
        end else begin
            diff = a_ext + (CNT_W + 1)'(DEPTH) - b_ext;
        end
        return ADDR_W'(diff);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/complex_value_stack_with_search_core.sv =====
// ============================================================================
// complex_value_stack_with_search_core: bounded stack of complex values
// Entries live in one circular synchronous memory of real/imaginary bit
// pattern pairs. Supports push on top, pop from top, push at bottom and a
// bitwise search that walks the stack from the top down.
// ============================================================================
//
//  Channel | Handshake                | Payload
//  --------+--------------------------+--------------------------------------
//  in      | i_in_valid / o_in_ready  | i_command, i_real_in, i_imag_in
//  out     | o_out_valid / i_out_ready| o_real_out, o_imag_out, o_found,
//          |                          | o_position, o_occupancy, o_status
//
//  Pushes and dropped commands go from accept straight to S_EMIT; a pop
//  first passes through S_POP while the memory read completes. A search
//  walks the stack in S_SRCH, issuing one memory read per cycle on the
//  single read port, and stops at the first hit.
//  Reset clears the top slot and entry count; the memory is not cleared.
//  One beat is in flight at a time; a finished result sits in the output
//  register so the next beat is accepted while it waits to be taken.
//
`default_nettype none

module complex_value_stack_with_search_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Command channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [cvss_pkg::CMD_W-1:0]  i_command,
    input  wire logic [cvss_pkg::DATA_W-1:0] i_real_in,
    input  wire logic [cvss_pkg::DATA_W-1:0] i_imag_in,
    // Result channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [cvss_pkg::DATA_W-1:0] o_real_out,
    output logic [cvss_pkg::DATA_W-1:0] o_imag_out,
    output logic                        o_found,
    output logic [cvss_pkg::POS_W-1:0]  o_position,
    output logic [cvss_pkg::OCC_W-1:0]  o_occupancy,
    output logic [cvss_pkg::ST_W-1:0]   o_status
);

    import cvss_pkg::*;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // Control registers
    logic [1:0] r_state, n_state;
    t_addr      r_top, n_top;
    t_cnt       r_count, n_count;
    t_addr      r_rd_ptr, n_rd_ptr;
    t_cnt       r_k, n_k;
    logic       r_cmp_valid, n_cmp_valid;
    logic       r_out_valid, n_out_valid;

    // Payload registers
    t_addr      r_cmp_k, n_cmp_k;
    t_data      r_key_re, n_key_re;
    t_data      r_key_im, n_key_im;
    t_data      r_res_re, n_res_re;
    t_data      r_res_im, n_res_im;
    logic       r_res_found, n_res_found;
    t_addr      r_res_pos, n_res_pos;
    t_status    r_res_status, n_res_status;
    t_data      r_out_re, n_out_re;
    t_data      r_out_im, n_out_im;
    logic       r_out_found, n_out_found;
    logic [POS_W-1:0] r_out_pos, n_out_pos;
    logic [OCC_W-1:0] r_out_occ, n_out_occ;
    t_status    r_out_status, n_out_status;

    // Memory and its ports
    logic [2*DATA_W-1:0] r_mem [DEPTH];
    logic [2*DATA_W-1:0] r_rd_data;
    t_addr               rd_addr;
    logic                wr_en;
    t_addr               wr_addr;

    logic accept;
    logic full;
    logic cmp_hit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign full        = (r_count == t_cnt'(DEPTH));
    assign cmp_hit     = r_cmp_valid && (r_rd_data == {r_key_re, r_key_im});
    assign rd_addr     = (r_state == S_SRCH) ? r_rd_ptr : r_top;

    assign o_out_valid = r_out_valid;
    assign o_real_out  = r_out_re;
    assign o_imag_out  = r_out_im;
    assign o_found     = r_out_found;
    assign o_position  = r_out_pos;
    assign o_occupancy = r_out_occ;
    assign o_status    = r_out_status;

    // Store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {i_real_in, i_imag_in};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Next-state logic for the sequencer, stack pointers and result path.
    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_count      = r_count;
        n_rd_ptr     = r_rd_ptr;
        n_k          = r_k;
        n_cmp_valid  = 1'b0;
        n_cmp_k      = r_cmp_k;
        n_key_re     = r_key_re;
        n_key_im     = r_key_im;
        n_res_re     = r_res_re;
        n_res_im     = r_res_im;
        n_res_found  = r_res_found;
        n_res_pos    = r_res_pos;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_re     = r_out_re;
        n_out_im     = r_out_im;
        n_out_found  = r_out_found;
        n_out_pos    = r_out_pos;
        n_out_occ    = r_out_occ;
        n_out_status = r_out_status;
        wr_en        = 1'b0;
        wr_addr      = r_top;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // Default result: zeros with an ok status.
                    n_res_re     = '0;
                    n_res_im     = '0;
                    n_res_found  = 1'b0;
                    n_res_pos    = '0;
                    n_res_status = ST_OK;
                    n_state      = S_EMIT;
                    case (i_command)
                        CMD_PUSH_TOP, CMD_PUSH_BOTTOM: begin
                            if (full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + t_cnt'(1);
                                if (i_command == CMD_PUSH_TOP) begin
                                    wr_addr = f_slot_next(r_top);
                                    n_top   = f_slot_next(r_top);
                                end else begin
                                    wr_addr = f_slot_back(r_top, r_count);
                                end
                            end
                        end
                        CMD_POP_TOP: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                // Memory read of the top slot is in flight.
                                n_top   = f_slot_back(r_top, t_cnt'(1));
                                n_count = r_count - t_cnt'(1);
                                n_state = S_POP;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count != '0) begin
                                n_key_re = i_real_in;
                                n_key_im = i_imag_in;
                                n_rd_ptr = r_top;
                                n_k      = '0;
                                n_state  = S_SRCH;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            S_POP: begin
                // Read data for the old top arrives this cycle.
                n_res_re = r_rd_data[2*DATA_W-1:DATA_W];
                n_res_im = r_rd_data[DATA_W-1:0];
                n_state  = S_EMIT;
            end

            S_SRCH: begin
                // Issue one read per cycle while entries remain.
                if (r_k != r_count) begin
                    n_rd_ptr    = f_slot_back(r_rd_ptr, t_cnt'(1));
                    n_k         = r_k + t_cnt'(1);
                    n_cmp_valid = 1'b1;
                    n_cmp_k     = t_addr'(r_k);
                end
                // Compare the entry read in the previous cycle.
                if (cmp_hit) begin
                    n_res_found = 1'b1;
                    n_res_pos   = r_cmp_k;
                    n_cmp_valid = 1'b0;
                    n_state     = S_EMIT;
                end else if (r_cmp_valid && (r_k == r_count)) begin
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                // Move the result into the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_re     = r_res_re;
                    n_out_im     = r_res_im;
                    n_out_found  = r_res_found;
                    n_out_pos    = POS_W'(r_res_pos);
                    n_out_occ    = OCC_W'(r_count);
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= '0;
            r_count     <= '0;
            r_rd_ptr    <= '0;
            r_k         <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_count     <= n_count;
            r_rd_ptr    <= n_rd_ptr;
            r_k         <= n_k;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_cmp_k      <= n_cmp_k;
        r_key_re     <= n_key_re;
        r_key_im     <= n_key_im;
        r_res_re     <= n_res_re;
        r_res_im     <= n_res_im;
        r_res_found  <= n_res_found;
        r_res_pos    <= n_res_pos;
        r_res_status <= n_res_status;
        r_out_re     <= n_out_re;
        r_out_im     <= n_out_im;
        r_out_found  <= n_out_found;
        r_out_pos    <= n_out_pos;
        r_out_occ    <= n_out_occ;
        r_out_status <= n_out_status;
    end

endmodule

`default_nettype wire
